[sv/tgc_pkg.sv]
// ----------------------------------------------------------------------------
// tgc_pkg
// Types and constants shared by the touch gesture classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tgc_pkg;

	localparam int COORD_BITS    = 10;
	localparam int TIME_BITS     = 32;
	localparam int LIMIT_BITS    = 16;
	localparam int DIST_BITS     = 10;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [LIMIT_BITS-1:0] SWIPE_TIME_RST = LIMIT_BITS'(500);
	localparam logic [DIST_BITS-1:0]  SWIPE_DIST_RST = DIST_BITS'(50);
	localparam logic [DIST_BITS-1:0]  TAP_DIST_RST   = DIST_BITS'(10);
	localparam logic [LIMIT_BITS-1:0] TAP_TIME_RST   = LIMIT_BITS'(200);

	typedef enum logic [2:0] {
		G_NONE  = 3'd0,
		G_UP    = 3'd1,
		G_DOWN  = 3'd2,
		G_LEFT  = 3'd3,
		G_RIGHT = 3'd4,
		G_TAP   = 3'd5
	} gesture_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SWIPE_TIME = 2'd0,
		CFG_SWIPE_DIST = 2'd1,
		CFG_TAP_DIST   = 2'd2,
		CFG_TAP_TIME   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic                  touched;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
		logic [TIME_BITS-1:0]  now_ms;
	} in_item_t;

	typedef struct packed {
		gesture_t              gesture;
		logic [COORD_BITS-1:0] origin_x;
		logic [COORD_BITS-1:0] origin_y;
	} out_item_t;

	typedef struct packed {
		logic [LIMIT_BITS-1:0] swipe_time_limit_ms;
		logic [DIST_BITS-1:0]  swipe_min_distance;
		logic [DIST_BITS-1:0]  tap_max_distance;
		logic [LIMIT_BITS-1:0] tap_time_limit_ms;
	} cfg_t;

	typedef struct packed {
		logic                  held;
		logic [COORD_BITS-1:0] first_x;
		logic [COORD_BITS-1:0] first_y;
		logic [COORD_BITS-1:0] latest_x;
		logic [COORD_BITS-1:0] latest_y;
		logic [TIME_BITS-1:0]  press_time;
	} track_t;

endpackage

`default_nettype wire

[sv/tgc_track.sv]
// ----------------------------------------------------------------------------
// tgc_track
// Press tracker: start point, start time and latest point of the held touch.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_track (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire tgc_pkg::in_item_t item,
	output tgc_pkg::track_t        track
);

	tgc_pkg::track_t track_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= '0;
		end else if (step) begin
			if (item.touched) begin
				if (!track_q.held) begin
					track_q.first_x    <= item.pos_x;
					track_q.first_y    <= item.pos_y;
					track_q.press_time <= item.now_ms;
					track_q.held       <= 1'b1;
				end
				track_q.latest_x <= item.pos_x;
				track_q.latest_y <= item.pos_y;
			end else begin
				// release clears everything, press or not
				track_q <= '0;
			end
		end
	end

	assign track = track_q;

endmodule

`default_nettype wire

[sv/tgc_classify.sv]
// ----------------------------------------------------------------------------
// tgc_classify
// Release classification: swipe direction, tap or none, with origin point.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_classify (
	input  wire tgc_pkg::in_item_t item,
	input  wire tgc_pkg::track_t   track,
	input  wire tgc_pkg::cfg_t     cfg,
	output tgc_pkg::out_item_t     result
);

	logic [tgc_pkg::COORD_BITS-1:0] ax;
	logic [tgc_pkg::COORD_BITS-1:0] ay;
	logic [tgc_pkg::TIME_BITS-1:0]  dur;
	logic                           swipe_ok;
	logic                           tap_time_ok;
	logic                           swipe_dist_x;
	logic                           swipe_dist_y;
	logic                           tap_near;
	tgc_pkg::gesture_t              g;

	assign ax = (track.latest_x >= track.first_x) ? track.latest_x - track.first_x
	                                              : track.first_x - track.latest_x;
	assign ay = (track.latest_y >= track.first_y) ? track.latest_y - track.first_y
	                                              : track.first_y - track.latest_y;

	// modular duration since press
	assign dur = item.now_ms - track.press_time;

	assign swipe_ok    = dur < tgc_pkg::TIME_BITS'(cfg.swipe_time_limit_ms);
	assign tap_time_ok = dur < tgc_pkg::TIME_BITS'(cfg.tap_time_limit_ms);

	// compare with both operands zero-extended to 32 bits
	assign swipe_dist_x = 32'(ax) > 32'(cfg.swipe_min_distance);
	assign swipe_dist_y = 32'(ay) > 32'(cfg.swipe_min_distance);
	assign tap_near     = (32'(ax) < 32'(cfg.tap_max_distance)) &&
	                      (32'(ay) < 32'(cfg.tap_max_distance));

	always_comb begin
		g = tgc_pkg::G_NONE;
		if (!item.touched && track.held && swipe_ok) begin
			if (ay > ax && swipe_dist_y) begin
				g = (track.latest_y > track.first_y) ? tgc_pkg::G_DOWN : tgc_pkg::G_UP;
			end else if (ax > ay && swipe_dist_x) begin
				g = (track.latest_x > track.first_x) ? tgc_pkg::G_RIGHT : tgc_pkg::G_LEFT;
			end else if (tap_near && tap_time_ok) begin
				g = tgc_pkg::G_TAP;
			end
		end
	end

	always_comb begin
		result.gesture  = g;
		result.origin_x = (g != tgc_pkg::G_NONE) ? track.first_x : '0;
		result.origin_y = (g != tgc_pkg::G_NONE) ? track.first_y : '0;
	end

endmodule

`default_nettype wire

[sv/touch_gesture_classifier_unit.sv]
// ----------------------------------------------------------------------------
// touch_gesture_classifier_unit
// Classifies touch-panel samples into swipes and taps, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one panel sample per
//   item: touched flag, coordinates and a millisecond timestamp. Every
//   accepted item yields exactly one result item on the output channel
//   (out_valid / out_stall / out_data): a gesture code plus the origin point
//   of the released press (zero when no gesture).
//   An accepted item is loaded into the input register, then moves on to the
//   result register once that register is empty or its item is taken.
//   Throughput: one item per cycle unless out_stall holds a waiting result;
//   the path between the two registers is the 32-bit duration subtract and
//   compare plus the delta compares. Stall: while out_stall holds a waiting
//   result, the input register still takes an item if it is empty; in_stall
//   rises only when both the input register and the result register are full.
//   Reset (arst_n low): no item in flight, no press held, the four limit
//   registers return to 500 ms, 50, 10 and 200 ms.
//   Configuration: cfg_wr_en writes cfg_data into register cfg_index. The user
//   must write only while the block is idle; the block itself leaves this unenforced.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_gesture_classifier_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [tgc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [tgc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire tgc_pkg::in_item_t                   in_data,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output tgc_pkg::out_item_t                       out_data
);

	tgc_pkg::cfg_t      cfg_q;
	logic               vld_s1;
	tgc_pkg::in_item_t  item_s1;
	logic               out_vld_q;
	tgc_pkg::out_item_t out_q;
	logic               adv;
	logic               fire_s1;
	tgc_pkg::track_t    track;
	tgc_pkg::out_item_t result;

	// Limit registers: write only, unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.swipe_time_limit_ms <= tgc_pkg::SWIPE_TIME_RST;
			cfg_q.swipe_min_distance  <= tgc_pkg::SWIPE_DIST_RST;
			cfg_q.tap_max_distance    <= tgc_pkg::TAP_DIST_RST;
			cfg_q.tap_time_limit_ms   <= tgc_pkg::TAP_TIME_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tgc_pkg::CFG_SWIPE_TIME: begin
					cfg_q.swipe_time_limit_ms <= cfg_data[tgc_pkg::LIMIT_BITS-1:0];
				end
				tgc_pkg::CFG_SWIPE_DIST: begin
					cfg_q.swipe_min_distance <= cfg_data[tgc_pkg::DIST_BITS-1:0];
				end
				tgc_pkg::CFG_TAP_DIST: begin
					cfg_q.tap_max_distance <= cfg_data[tgc_pkg::DIST_BITS-1:0];
				end
				tgc_pkg::CFG_TAP_TIME: begin
					cfg_q.tap_time_limit_ms <= cfg_data[tgc_pkg::LIMIT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Result register moves when empty or when its item is taken.
	assign adv      = !out_vld_q || !out_stall;
	assign fire_s1  = vld_s1 && adv;
	assign in_stall = vld_s1 && !adv;

	// Input register: hold while the result side is blocked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Press state advances once per item, in order, as it leaves stage one.
	tgc_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire_s1),
		.item   (item_s1),
		.track  (track)
	);

	tgc_classify u_classify (
		.item   (item_s1),
		.track  (track),
		.cfg    (cfg_q),
		.result (result)
	);

	// Result register: hold a stalled item, load the next one otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= result;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

[sv/tgc_checker.sv]
// ----------------------------------------------------------------------------
// tgc_checker
// Port-level checks for the touch gesture classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire tgc_pkg::out_item_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result item changed");

	// input side blocks only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.gesture <= tgc_pkg::G_TAP)
		else $error("gesture code out of range");

	a_none_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.gesture == tgc_pkg::G_NONE |->
		out_data.origin_x == '0 && out_data.origin_y == '0)
		else $error("origin not zero without a gesture");

endmodule

bind touch_gesture_classifier_unit tgc_checker u_tgc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire

[bench/touch_gesture_classifier_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_classifier_checker
// Watches both channels of the gesture classifier, predicts one result per
// accepted sample from its own press tracker and compares in order.
// ----------------------------------------------------------------------------

module touch_gesture_classifier_checker
	import tgc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                     in_valid,
	input  wire logic                     in_stall,
	input  wire in_item_t                 in_data,
	input  wire logic                     out_valid,
	input  wire logic                     out_stall,
	input  wire out_item_t                out_data,
	output int                            mismatches,
	output int                            outstanding,
	output int                            results_checked,
	output int                            gestures_found
);

	cfg_t                  limits;
	logic                  pressed;
	logic [COORD_BITS-1:0] down_x, down_y, last_x, last_y;
	logic [TIME_BITS-1:0]  down_ms;
	out_item_t             due_q[$];
	int                    fail_count, checked_count, gesture_count;

	// Classify the press being released after span_ms of contact.
	function automatic gesture_t judge_release(input logic [TIME_BITS-1:0] span_ms);
		logic [COORD_BITS-1:0] ax, ay;
		ax = (last_x >= down_x) ? last_x - down_x : down_x - last_x;
		ay = (last_y >= down_y) ? last_y - down_y : down_y - last_y;
		if (span_ms >= TIME_BITS'(limits.swipe_time_limit_ms))
			return G_NONE;
		if (ay > ax && ay > limits.swipe_min_distance) begin
			if (last_y > down_y)
				return G_DOWN;
			return G_UP;
		end
		if (ax > ay && ax > limits.swipe_min_distance) begin
			if (last_x > down_x)
				return G_RIGHT;
			return G_LEFT;
		end
		if (ax < limits.tap_max_distance && ay < limits.tap_max_distance &&
				span_ms < TIME_BITS'(limits.tap_time_limit_ms))
			return G_TAP;
		return G_NONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want, got;
		if (!arst_n) begin
			limits          = '{SWIPE_TIME_RST, SWIPE_DIST_RST, TAP_DIST_RST, TAP_TIME_RST};
			pressed         = 1'b0;
			down_x          = '0;
			down_y          = '0;
			last_x          = '0;
			last_y          = '0;
			down_ms         = '0;
			fail_count      = 0;
			checked_count   = 0;
			gesture_count   = 0;
			due_q.delete();
			mismatches      <= 0;
			outstanding     <= 0;
			results_checked <= 0;
			gestures_found  <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
				CFG_SWIPE_TIME: limits.swipe_time_limit_ms = cfg_data[LIMIT_BITS-1:0];
				CFG_SWIPE_DIST: limits.swipe_min_distance = cfg_data[DIST_BITS-1:0];
				CFG_TAP_DIST:   limits.tap_max_distance = cfg_data[DIST_BITS-1:0];
				CFG_TAP_TIME:   limits.tap_time_limit_ms = cfg_data[LIMIT_BITS-1:0];
				default: ;
				endcase
			end

			// compare before predicting: a result never leaves on its own item's edge
			if (out_valid && !out_stall) begin
				got = out_data;
				if (due_q.size() == 0) begin
					$error("unexpected result: gesture %0d origin (%0d,%0d)",
						got.gesture, got.origin_x, got.origin_y);
					fail_count++;
				end else begin
					want = due_q.pop_front();
					checked_count++;
					if (want.gesture != G_NONE)
						gesture_count++;
					if (got.gesture !== want.gesture) begin
						$error("gesture: expected %0d, got %0d", want.gesture, got.gesture);
						fail_count++;
					end
					if (got.origin_x !== want.origin_x) begin
						$error("origin_x: expected %0d, got %0d", want.origin_x, got.origin_x);
						fail_count++;
					end
					if (got.origin_y !== want.origin_y) begin
						$error("origin_y: expected %0d, got %0d", want.origin_y, got.origin_y);
						fail_count++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				want = '0;
				if (in_data.touched) begin
					if (!pressed) begin
						down_x  = in_data.pos_x;
						down_y  = in_data.pos_y;
						down_ms = in_data.now_ms;
						pressed = 1'b1;
					end
					last_x = in_data.pos_x;
					last_y = in_data.pos_y;
				end else begin
					if (pressed)
						want.gesture = judge_release(in_data.now_ms - down_ms);
					if (want.gesture != G_NONE) begin
						want.origin_x = down_x;
						want.origin_y = down_y;
					end
					pressed = 1'b0;
					down_x  = '0;
					down_y  = '0;
					last_x  = '0;
					last_y  = '0;
					down_ms = '0;
				end
				due_q.push_back(want);
			end

			mismatches      <= fail_count;
			outstanding     <= due_q.size();
			results_checked <= checked_count;
			gestures_found  <= gesture_count;
		end
	end

endmodule

[bench/touch_gesture_classifier_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_classifier_unit_test
// Drives touch samples into the gesture classifier under several limit
// settings and both-side idling; a checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------

module touch_gesture_classifier_unit_test;
	import tgc_pkg::*;

	localparam int COORD_MAX           = (1 << COORD_BITS) - 1;
	localparam int LIMIT_SETTINGS      = 6;
	localparam int SAMPLES_PER_SETTING = 135;
	localparam int OUT_HOLD_CYCLES     = 60;

	// every block input starts at a known value
	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
	logic                     in_valid  = 1'b0;
	in_item_t                 in_data   = '0;
	logic                     out_stall = 1'b0;
	logic                     in_stall;
	logic                     out_valid;
	out_item_t                out_data;

	int mismatches, outstanding, results_checked, gestures_found;

	// limits currently loaded in the block, used to aim the random presses
	cfg_t limits = '{SWIPE_TIME_RST, SWIPE_DIST_RST, TAP_DIST_RST, TAP_TIME_RST};

	// idling odds in percent; the receiver reads its own at every falling edge
	int tx_idle_pct   = 29;
	int rx_idle_pct   = 77;
	int burst_request = 0;
	int stall_run     = 0;
	logic burst_taken = 1'b0;

	int samples_sent    = 0;
	int setting_samples = 0;
	int directed_count  = 0;

	always #6 clk = ~clk;

	touch_gesture_classifier_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	touch_gesture_classifier_checker gesture_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.gestures_found  (gestures_found)
	);

	// Receiver: stall at random, or hold off for a whole burst once one is
	// requested. The burst is counted here so the sender keeps going meanwhile.
	always @(negedge clk) begin
		if (burst_request > 0 && !burst_taken) begin
			stall_run   = burst_request;
			burst_taken = 1'b1;
		end
		if (stall_run > 0) begin
			stall_run--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// Offer one sample: idle for a random gap, then hold it until accepted.
	task automatic offer(input logic touched, input int unsigned x, input int unsigned y,
			input logic [TIME_BITS-1:0] stamp);
		in_item_t item;
		item.touched = touched;
		item.pos_x   = COORD_BITS'(x);
		item.pos_y   = COORD_BITS'(y);
		item.now_ms  = stamp;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			in_data.now_ms <= $urandom;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall);
		samples_sent++;
		setting_samples++;
	endtask

	// Drop valid and wait until every result has come back, plus the pipeline.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Movement length on one axis, mostly aimed at the current thresholds.
	function automatic int unsigned pick_span();
		int near;
		case ($urandom_range(0, 3))
		0: return $urandom_range(0, limits.tap_max_distance + 1);
		1: begin
			near = int'(limits.swipe_min_distance) + int'($urandom_range(0, 2)) - 1;
			return (near < 0) ? 0 : near;
		end
		2: return $urandom_range(0, COORD_MAX);
		default: return $urandom_range(0, 120);
		endcase
	endfunction

	// End coordinate span away from 'from', kept on the panel.
	function automatic int unsigned land(input int unsigned from, input int unsigned span);
		if ($urandom_range(0, 1) == 1 && from >= span)
			return from - span;
		if (from + span <= COORD_MAX)
			return from + span;
		if (from >= span)
			return from - span;
		return COORD_MAX;
	endfunction

	initial begin : stimulus
		cfg_t                 lim;
		logic [5:0]           high_junk;
		int unsigned          sx, sy, ax, ay, hops;
		logic [TIME_BITS-1:0] t0, hold_ms, nudge;

		// hold reset, then release it away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed presses under the reset limits: 500 ms, 50, 10, 200 ms.
		// release with no press held
		offer(1'b0, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
		// tap at the corner, one ms inside the tap time
		offer(1'b1, 0, 0, 32'd0);
		offer(1'b0, 0, 0, 32'd199);
		// swipe down while the timestamp wraps, 300 ms
		offer(1'b1, 100, 100, 32'hFFFF_FF00);
		offer(1'b1, 100, 400, 32'd0);
		offer(1'b0, 7, 9, 32'h0000_002C);
		// swipe up from the bottom edge, one ms under the swipe time
		offer(1'b1, 512, COORD_MAX, 32'd1000);
		offer(1'b1, 512, 0, 32'd1100);
		offer(1'b0, 0, 0, 32'd1499);
		// swipe left across the full width
		offer(1'b1, COORD_MAX, 500, 32'd5);
		offer(1'b1, 0, 500, 32'd6);
		offer(1'b0, 0, 0, 32'd105);
		// swipe right along the far edge
		offer(1'b1, 0, COORD_MAX, 32'd7);
		offer(1'b1, COORD_MAX, COORD_MAX, 32'd8);
		offer(1'b0, COORD_MAX, COORD_MAX, 32'd57);
		// equal deltas: no swipe, and too far for a tap
		offer(1'b1, 200, 200, 32'd10);
		offer(1'b1, 300, 300, 32'd11);
		offer(1'b0, 0, 0, 32'd20);
		// duration equal to the swipe time gives nothing
		offer(1'b1, 600, 600, 32'd0);
		offer(1'b1, 600, 800, 32'd1);
		offer(1'b0, 0, 0, 32'd500);
		// still press held exactly the tap time
		offer(1'b1, 40, 40, 32'd3);
		offer(1'b0, 0, 0, 32'd203);
		// movement equal to the tap distance
		offer(1'b1, 50, 50, 32'd0);
		offer(1'b1, 60, 50, 32'd1);
		offer(1'b0, 0, 0, 32'd5);
		directed_count = samples_sent;
		settle();

		for (int setting = 0; setting < LIMIT_SETTINGS; setting++) begin
			// receiver sparse first, then sender sparse, then both flat out
			tx_idle_pct = (setting < 2) ? 29 : (setting < 4) ? 77 : 0;
			rx_idle_pct = (setting < 2) ? 77 : (setting < 4) ? 29 : 0;
			// long output hold while the sender keeps pushing: fills the block
			if (setting == 4)
				burst_request = OUT_HOLD_CYCLES;

			high_junk = 6'($urandom);
			case (setting)
			0, 3: lim = '{LIMIT_BITS'($urandom_range(100, 2000)),
					DIST_BITS'($urandom_range(0, 300)),
					DIST_BITS'($urandom_range(0, 60)),
					LIMIT_BITS'($urandom_range(0, 1000))};
			1: begin
				// everything zero: no gesture can pass
				lim = '0;
				high_junk = '0;
			end
			2: begin
				// everything at full scale, distance upper bits set as well
				lim = '1;
				high_junk = '1;
			end
			4: lim = '{'1, '0, '1, '1};
			default: lim = '{LIMIT_BITS'($urandom), DIST_BITS'($urandom),
					DIST_BITS'($urandom), LIMIT_BITS'($urandom)};
			endcase

			// load all four registers on consecutive edges, block idle
			@(negedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_SWIPE_TIME;
			cfg_data  <= lim.swipe_time_limit_ms;
			@(negedge clk);
			cfg_index <= CFG_SWIPE_DIST;
			cfg_data  <= {high_junk, lim.swipe_min_distance};
			@(negedge clk);
			cfg_index <= CFG_TAP_DIST;
			cfg_data  <= {high_junk, lim.tap_max_distance};
			@(negedge clk);
			cfg_index <= CFG_TAP_TIME;
			cfg_data  <= lim.tap_time_limit_ms;
			@(negedge clk);
			cfg_wr_en <= 1'b0;
			limits = lim;

			setting_samples = 0;
			while (setting_samples < SAMPLES_PER_SETTING) begin
				if ($urandom_range(0, 99) < 85) begin
					// a whole press: down, optional wandering and final point, release
					sx = $urandom_range(0, COORD_MAX);
					sy = $urandom_range(0, COORD_MAX);
					ax = pick_span();
					ay = ($urandom_range(0, 5) == 0) ? ax : pick_span();
					t0 = $urandom;
					nudge = TIME_BITS'($urandom_range(0, 2)) - 1;
					case ($urandom_range(0, 4))
					0: hold_ms = $urandom_range(0, 5);
					1: hold_ms = TIME_BITS'(limits.tap_time_limit_ms) + nudge;
					2: hold_ms = TIME_BITS'(limits.swipe_time_limit_ms) + nudge;
					3: hold_ms = $urandom;
					default: hold_ms = $urandom_range(0, limits.swipe_time_limit_ms);
					endcase
					offer(1'b1, sx, sy, t0);
					hops = $urandom_range(0, 3);
					repeat (hops)
						offer(1'b1, $urandom_range(0, COORD_MAX),
							$urandom_range(0, COORD_MAX), $urandom);
					if (hops > 0 || $urandom_range(0, 3) != 0)
						offer(1'b1, land(sx, ax), land(sy, ay), $urandom);
					offer(1'b0, $urandom_range(0, COORD_MAX),
						$urandom_range(0, COORD_MAX), t0 + hold_ms);
				end else begin
					// stray sample: breaks or restarts whatever press is open
					offer(1'($urandom_range(0, 1)), $urandom_range(0, COORD_MAX),
						$urandom_range(0, COORD_MAX), $urandom);
				end
			end
			settle();
		end

		$display("Covered %0d samples (%0d directed) over %0d limit settings,",
			samples_sent, directed_count, LIMIT_SETTINGS);
		$display("%0d-cycle output hold; compared %0d results, %0d swipes or taps.",
			OUT_HOLD_CYCLES, results_checked, gestures_found);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
sv/tgc_pkg.sv
sv/tgc_track.sv
sv/tgc_classify.sv
sv/touch_gesture_classifier_unit.sv
sv/tgc_checker.sv
bench/touch_gesture_classifier_checker.sv
bench/touch_gesture_classifier_unit_test.sv
